>>> hw/rtl/kbib_pkg.sv
// ----------------------------------------------------------------------------
// kbib_pkg
// Shared types, constants and helpers of the k-mer bucket index builder.
// ----------------------------------------------------------------------------
package kbib_pkg;

    localparam int KMER_LENGTH = 8;
    localparam int SEQ_DEPTH   = 65536;
    localparam int SAW         = $clog2(SEQ_DEPTH);
    localparam int CW          = SAW + 1;
    localparam int HW          = 2 * KMER_LENGTH;
    localparam int DIR_SIZE    = 1 << HW;
    localparam int DIR_DEPTH   = DIR_SIZE + 1;
    localparam int DAW         = HW + 1;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_BUILD  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_BUILT = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd        command;
        logic [1:0]  base;
        logic [15:0] query_kmer;
        logic [15:0] entry_index;
    } t_in;

    typedef struct packed {
        t_status     status;
        logic [16:0] window_count;
        logic [16:0] bucket_begin;
        logic [16:0] bucket_end;
        logic [15:0] position;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLEAR,
        S_PRIME_RD,
        S_PRIME_WT,
        S_WIN_RD,
        S_WIN_UPD,
        S_PFX_RD,
        S_PFX_WR,
        S_QRY_RD0,
        S_QRY_RD1,
        S_QRY_DONE,
        S_ENT_RD,
        S_ENT_DONE
    } t_state;

    // Shift the window by one base: the new base enters the top digit.
    function automatic logic [HW-1:0] roll(input logic [HW-1:0] h, input logic [1:0] b);
        logic [HW-1:0] shifted;
        shifted = h >> 2;
        shifted[HW-1 -: 2] = b;
        return shifted;
    endfunction

endpackage

>>> hw/rtl/kmer_bucket_index_builder.sv
// ----------------------------------------------------------------------------
// kmer_bucket_index_builder
// Stores a 2-bit base sequence and builds a bucket index of its k-mers.
// ----------------------------------------------------------------------------
// Each accepted transaction produces exactly one result, strobed for one cycle
// and not held, so the receiver must take it when o_strobe is high. busy is
// high from the cycle after start until the result cycle. An append and any
// error answer straight from the dispatch state; a query first reads two
// directory entries and a read one position entry. A build walks the bucket
// directory memory with its single read port and single write port: one
// clearing sweep over the 4^K+1 directory entries, a prefix sum over the same
// entries, and for n > 0 windows two passes through the shared rolling hash,
// each priming K bases and then visiting the n windows in turn.
// ----------------------------------------------------------------------------
module kmer_bucket_index_builder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  kbib_pkg::t_in i_item,
    output logic          o_strobe,
    output kbib_pkg::t_out o_result
);

    kbib_pkg::t_state r_state, n_state;
    kbib_pkg::t_in    r_item, n_item;
    logic [kbib_pkg::CW-1:0]  r_base_count, n_base_count;
    logic                     r_valid, n_valid;
    logic [kbib_pkg::CW-1:0]  r_built, n_built;
    logic [kbib_pkg::CW-1:0]  r_n, n_n;
    logic [kbib_pkg::HW-1:0]  r_hash, n_hash;
    logic [kbib_pkg::CW-1:0]  r_idx, n_idx;
    logic [kbib_pkg::DAW-1:0] r_dir_idx, n_dir_idx;
    logic [kbib_pkg::CW-1:0]  r_acc, n_acc;
    logic                     r_pass, n_pass;
    logic [kbib_pkg::CW-1:0]  r_begin, n_begin;
    logic                     r_strobe, n_strobe;
    kbib_pkg::t_out           r_result, n_result;

    logic                     seq_we;
    logic [kbib_pkg::SAW-1:0] seq_waddr, seq_raddr;
    logic [1:0]               seq_rdata;
    logic                     dir_we;
    logic [kbib_pkg::DAW-1:0] dir_waddr, dir_raddr;
    logic [kbib_pkg::CW-1:0]  dir_wdata, dir_rdata;
    logic                     pos_we;
    logic [kbib_pkg::SAW-1:0] pos_waddr, pos_raddr;
    logic [15:0]              pos_wdata, pos_rdata;

    logic [kbib_pkg::DAW-1:0] hash_slot;
    logic [kbib_pkg::CW-1:0]  idx_next;
    logic                     more_windows;
    logic [16:0]              cur_windows;

    assign hash_slot    = kbib_pkg::DAW'(r_hash) + kbib_pkg::DAW'(1);
    assign idx_next     = r_idx + kbib_pkg::CW'(1);
    assign more_windows = (idx_next < r_n);
    assign cur_windows  = r_valid ? 17'(r_built) : 17'd0;

    kbib_ram #(.DEPTH(kbib_pkg::SEQ_DEPTH), .WIDTH(2)) u_seq (
        .i_clk(i_clk), .i_we(seq_we), .i_waddr(seq_waddr), .i_wdata(r_item.base),
        .i_raddr(seq_raddr), .o_rdata(seq_rdata)
    );

    kbib_ram #(.DEPTH(kbib_pkg::DIR_DEPTH), .WIDTH(kbib_pkg::CW)) u_dir (
        .i_clk(i_clk), .i_we(dir_we), .i_waddr(dir_waddr), .i_wdata(dir_wdata),
        .i_raddr(dir_raddr), .o_rdata(dir_rdata)
    );

    kbib_ram #(.DEPTH(kbib_pkg::SEQ_DEPTH), .WIDTH(16)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(pos_waddr), .i_wdata(pos_wdata),
        .i_raddr(pos_raddr), .o_rdata(pos_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            kbib_pkg::S_IDLE: begin
                if (start) begin
                    n_state = kbib_pkg::S_DISPATCH;
                end
            end
            kbib_pkg::S_DISPATCH: begin
                n_state = kbib_pkg::S_IDLE;
                case (r_item.command)
                    kbib_pkg::CMD_BUILD: n_state = kbib_pkg::S_CLEAR;
                    kbib_pkg::CMD_QUERY: begin
                        if (r_valid && (32'(r_item.query_kmer) < kbib_pkg::DIR_SIZE)) begin
                            n_state = kbib_pkg::S_QRY_RD0;
                        end
                    end
                    kbib_pkg::CMD_READ: begin
                        if (r_valid && ({1'b0, r_item.entry_index} < 17'(r_built))
                                && (32'(r_item.entry_index) < kbib_pkg::SEQ_DEPTH)) begin
                            n_state = kbib_pkg::S_ENT_RD;
                        end
                    end
                    default: n_state = kbib_pkg::S_IDLE;
                endcase
            end
            kbib_pkg::S_CLEAR: begin
                if (r_dir_idx == kbib_pkg::DAW'(kbib_pkg::DIR_SIZE)) begin
                    n_state = (r_n != '0) ? kbib_pkg::S_PRIME_RD : kbib_pkg::S_PFX_RD;
                end
            end
            kbib_pkg::S_PRIME_RD: n_state = kbib_pkg::S_PRIME_WT;
            kbib_pkg::S_PRIME_WT: begin
                if (r_idx == kbib_pkg::CW'(kbib_pkg::KMER_LENGTH - 1)) begin
                    n_state = kbib_pkg::S_WIN_RD;
                end else begin
                    n_state = kbib_pkg::S_PRIME_RD;
                end
            end
            kbib_pkg::S_WIN_RD: n_state = kbib_pkg::S_WIN_UPD;
            kbib_pkg::S_WIN_UPD: begin
                if (more_windows) begin
                    n_state = kbib_pkg::S_WIN_RD;
                end else if (!r_pass) begin
                    n_state = kbib_pkg::S_PFX_RD;
                end else begin
                    n_state = kbib_pkg::S_IDLE;
                end
            end
            kbib_pkg::S_PFX_RD: n_state = kbib_pkg::S_PFX_WR;
            kbib_pkg::S_PFX_WR: begin
                if (r_dir_idx == kbib_pkg::DAW'(kbib_pkg::DIR_SIZE)) begin
                    n_state = (r_n != '0) ? kbib_pkg::S_PRIME_RD : kbib_pkg::S_IDLE;
                end else begin
                    n_state = kbib_pkg::S_PFX_RD;
                end
            end
            kbib_pkg::S_QRY_RD0: n_state = kbib_pkg::S_QRY_RD1;
            kbib_pkg::S_QRY_RD1: n_state = kbib_pkg::S_QRY_DONE;
            kbib_pkg::S_QRY_DONE: n_state = kbib_pkg::S_IDLE;
            kbib_pkg::S_ENT_RD: n_state = kbib_pkg::S_ENT_DONE;
            kbib_pkg::S_ENT_DONE: n_state = kbib_pkg::S_IDLE;
            default: n_state = kbib_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_item       = r_item;
        n_base_count = r_base_count;
        n_valid      = r_valid;
        n_built      = r_built;
        n_n          = r_n;
        n_hash       = r_hash;
        n_idx        = r_idx;
        n_dir_idx    = r_dir_idx;
        n_acc        = r_acc;
        n_pass       = r_pass;
        n_begin      = r_begin;
        n_strobe     = 1'b0;
        n_result     = r_result;
        seq_we       = 1'b0;
        seq_waddr    = r_base_count[kbib_pkg::SAW-1:0];
        seq_raddr    = r_idx[kbib_pkg::SAW-1:0];
        dir_we       = 1'b0;
        dir_waddr    = r_dir_idx;
        dir_wdata    = '0;
        dir_raddr    = r_dir_idx;
        pos_we       = 1'b0;
        pos_waddr    = dir_rdata[kbib_pkg::SAW-1:0];
        pos_wdata    = 16'(r_idx);
        pos_raddr    = r_item.entry_index[kbib_pkg::SAW-1:0];
        case (r_state)
            kbib_pkg::S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                end
            end
            kbib_pkg::S_DISPATCH: begin
                n_result = '{status: kbib_pkg::ST_OK, window_count: cur_windows,
                             bucket_begin: 17'd0, bucket_end: 17'd0, position: 16'd0};
                n_strobe = 1'b1;
                case (r_item.command)
                    kbib_pkg::CMD_APPEND: begin
                        if (r_base_count == kbib_pkg::CW'(kbib_pkg::SEQ_DEPTH)) begin
                            n_result.status = kbib_pkg::ST_FULL;
                        end else begin
                            seq_we                = 1'b1;
                            n_base_count          = r_base_count + kbib_pkg::CW'(1);
                            n_valid               = 1'b0;
                            n_result.window_count = 17'd0;
                        end
                    end
                    kbib_pkg::CMD_BUILD: begin
                        n_strobe  = 1'b0;
                        n_dir_idx = '0;
                        n_valid   = 1'b0;
                        if (r_base_count >= kbib_pkg::CW'(kbib_pkg::KMER_LENGTH)) begin
                            n_n = r_base_count - kbib_pkg::CW'(kbib_pkg::KMER_LENGTH)
                                  + kbib_pkg::CW'(1);
                        end else begin
                            n_n = '0;
                        end
                    end
                    kbib_pkg::CMD_QUERY: begin
                        if (!r_valid) begin
                            n_result.status = kbib_pkg::ST_NOT_BUILT;
                        end else if (32'(r_item.query_kmer) >= kbib_pkg::DIR_SIZE) begin
                            n_result.status = kbib_pkg::ST_RANGE;
                        end else begin
                            n_strobe = 1'b0;
                        end
                    end
                    default: begin
                        if (!r_valid) begin
                            n_result.status = kbib_pkg::ST_NOT_BUILT;
                        end else if (({1'b0, r_item.entry_index} >= 17'(r_built))
                                || (32'(r_item.entry_index) >= kbib_pkg::SEQ_DEPTH)) begin
                            n_result.status = kbib_pkg::ST_RANGE;
                        end else begin
                            n_strobe = 1'b0;
                        end
                    end
                endcase
            end
            kbib_pkg::S_CLEAR: begin
                dir_we = 1'b1;
                if (r_dir_idx == kbib_pkg::DAW'(kbib_pkg::DIR_SIZE)) begin
                    n_dir_idx = '0;
                    n_acc     = '0;
                    n_pass    = 1'b0;
                    n_hash    = '0;
                    n_idx     = '0;
                end else begin
                    n_dir_idx = r_dir_idx + kbib_pkg::DAW'(1);
                end
            end
            kbib_pkg::S_PRIME_RD: begin
                seq_raddr = r_idx[kbib_pkg::SAW-1:0];
            end
            kbib_pkg::S_PRIME_WT: begin
                n_hash = kbib_pkg::roll(r_hash, seq_rdata);
                if (r_idx == kbib_pkg::CW'(kbib_pkg::KMER_LENGTH - 1)) begin
                    n_idx = '0;
                end else begin
                    n_idx = idx_next;
                end
            end
            kbib_pkg::S_WIN_RD: begin
                dir_raddr = hash_slot;
                seq_raddr = kbib_pkg::SAW'(r_idx + kbib_pkg::CW'(kbib_pkg::KMER_LENGTH));
            end
            kbib_pkg::S_WIN_UPD: begin
                dir_we    = 1'b1;
                dir_waddr = hash_slot;
                dir_wdata = dir_rdata + kbib_pkg::CW'(1);
                if (r_pass && (dir_rdata < kbib_pkg::CW'(kbib_pkg::SEQ_DEPTH))) begin
                    pos_we = 1'b1;
                end
                if (more_windows) begin
                    n_hash = kbib_pkg::roll(r_hash, seq_rdata);
                    n_idx  = idx_next;
                end else if (!r_pass) begin
                    n_dir_idx = '0;
                    n_acc     = '0;
                end else begin
                    n_valid  = 1'b1;
                    n_built  = r_n;
                    n_strobe = 1'b1;
                    n_result = '{status: kbib_pkg::ST_OK, window_count: 17'(r_n),
                                 bucket_begin: 17'd0, bucket_end: 17'd0, position: 16'd0};
                end
            end
            kbib_pkg::S_PFX_RD: begin
                dir_raddr = r_dir_idx;
            end
            kbib_pkg::S_PFX_WR: begin
                dir_we    = 1'b1;
                dir_wdata = r_acc;
                n_acc     = r_acc + dir_rdata;
                if (r_dir_idx == kbib_pkg::DAW'(kbib_pkg::DIR_SIZE)) begin
                    if (r_n != '0) begin
                        n_pass = 1'b1;
                        n_hash = '0;
                        n_idx  = '0;
                    end else begin
                        n_valid  = 1'b1;
                        n_built  = r_n;
                        n_strobe = 1'b1;
                        n_result = '{status: kbib_pkg::ST_OK, window_count: 17'(r_n),
                                     bucket_begin: 17'd0, bucket_end: 17'd0, position: 16'd0};
                    end
                end else begin
                    n_dir_idx = r_dir_idx + kbib_pkg::DAW'(1);
                end
            end
            kbib_pkg::S_QRY_RD0: begin
                dir_raddr = kbib_pkg::DAW'(r_item.query_kmer);
            end
            kbib_pkg::S_QRY_RD1: begin
                dir_raddr = kbib_pkg::DAW'(r_item.query_kmer) + kbib_pkg::DAW'(1);
                n_begin   = dir_rdata;
            end
            kbib_pkg::S_QRY_DONE: begin
                n_strobe = 1'b1;
                n_result = '{status: kbib_pkg::ST_OK, window_count: cur_windows,
                             bucket_begin: 17'(r_begin), bucket_end: 17'(dir_rdata),
                             position: 16'd0};
            end
            kbib_pkg::S_ENT_RD: begin
                pos_raddr = r_item.entry_index[kbib_pkg::SAW-1:0];
            end
            kbib_pkg::S_ENT_DONE: begin
                n_strobe = 1'b1;
                n_result = '{status: kbib_pkg::ST_OK, window_count: cur_windows,
                             bucket_begin: 17'd0, bucket_end: 17'd0, position: pos_rdata};
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= kbib_pkg::S_IDLE;
            r_base_count <= '0;
            r_valid      <= 1'b0;
            r_built      <= '0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_base_count <= n_base_count;
            r_valid      <= n_valid;
            r_built      <= n_built;
            r_strobe     <= n_strobe;
        end
        r_item    <= n_item;
        r_n       <= n_n;
        r_hash    <= n_hash;
        r_idx     <= n_idx;
        r_dir_idx <= n_dir_idx;
        r_acc     <= n_acc;
        r_pass    <= n_pass;
        r_begin   <= n_begin;
        r_result  <= n_result;
    end

    assign busy     = (r_state != kbib_pkg::S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

>>> hw/rtl/kbib_ram.sv
// ----------------------------------------------------------------------------
// kbib_ram
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module kbib_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> hw/rtl/kbib_checker.sv
// ----------------------------------------------------------------------------
// kbib_checker
// Port-level checks of the k-mer bucket index builder, bound to the top level.
// ----------------------------------------------------------------------------
module kbib_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input logic           o_strobe,
    input kbib_pkg::t_out o_result
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("Accepted transaction did not raise busy.");

    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !busy))
        else $error("Result strobed without a transaction in flight.");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("Result strobed twice for one transaction.");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != kbib_pkg::ST_OK)) |->
        ((o_result.bucket_begin == 17'd0) && (o_result.bucket_end == 17'd0)
         && (o_result.position == 16'd0)))
        else $error("Failed transaction returned nonzero data.");

endmodule

bind kmer_bucket_index_builder kbib_checker u_kbib_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .o_strobe(o_strobe),
    .o_result(o_result)
);

>>> tb/sv/kmer_bucket_index_builder_tb.sv
// ----------------------------------------------------------------------------
// kmer_bucket_index_builder_tb
// Drives appends, builds, queries and reads into the k-mer bucket index
// builder, predicts every result with an internal index model, and compares
// each strobed result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module kmer_bucket_index_builder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000000;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    kbib_pkg::t_in   i_item;
    logic            o_strobe;
    kbib_pkg::t_out  o_result;

    logic [1:0]      seq_mem [kbib_pkg::SEQ_DEPTH];
    logic [16:0]     bucket_dir [kbib_pkg::DIR_DEPTH];
    logic [15:0]     pos_mem [kbib_pkg::SEQ_DEPTH];
    int              seq_len;
    int              win_count;
    bit              idx_ok;
    kbib_pkg::t_out  result_fifo [$];
    int              error_count;
    int              idle_pct;
    int              builds_done;

    kmer_bucket_index_builder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [kbib_pkg::HW-1:0] hash_at(int p);
        logic [kbib_pkg::HW-1:0] h;
        h = '0;
        for (int i = 0; i < kbib_pkg::KMER_LENGTH; i++) begin
            h[2*i +: 2] = seq_mem[p + i];
        end
        return h;
    endfunction

    function automatic void build_index();
        int n;
        int acc;
        int c;
        n = (seq_len >= kbib_pkg::KMER_LENGTH) ? seq_len - kbib_pkg::KMER_LENGTH + 1 : 0;
        for (int j = 0; j < kbib_pkg::DIR_DEPTH; j++) bucket_dir[j] = '0;
        for (int i = 0; i < n; i++) bucket_dir[hash_at(i) + 1]++;
        acc = 0;
        for (int j = 0; j < kbib_pkg::DIR_DEPTH; j++) begin
            c = bucket_dir[j];
            bucket_dir[j] = 17'(acc);
            acc += c;
        end
        for (int i = 0; i < n; i++) begin
            c = hash_at(i) + 1;
            pos_mem[bucket_dir[c]] = 16'(i);
            bucket_dir[c]++;
        end
        win_count = n;
        idx_ok = 1'b1;
    endfunction

    function automatic kbib_pkg::t_out predict_result(kbib_pkg::t_in it);
        kbib_pkg::t_out r;
        r = '0;
        case (it.command)
            kbib_pkg::CMD_APPEND: begin
                if (seq_len >= kbib_pkg::SEQ_DEPTH) begin
                    r.status = kbib_pkg::ST_FULL;
                end else begin
                    seq_mem[seq_len] = it.base;
                    seq_len++;
                    idx_ok = 1'b0;
                end
            end
            kbib_pkg::CMD_BUILD: build_index();
            kbib_pkg::CMD_QUERY: begin
                if (!idx_ok) r.status = kbib_pkg::ST_NOT_BUILT;
                else if (int'(it.query_kmer) >= kbib_pkg::DIR_SIZE) r.status = kbib_pkg::ST_RANGE;
                else begin
                    r.bucket_begin = bucket_dir[it.query_kmer];
                    r.bucket_end   = bucket_dir[int'(it.query_kmer) + 1];
                end
            end
            default: begin
                if (!idx_ok) r.status = kbib_pkg::ST_NOT_BUILT;
                else if (int'(it.entry_index) >= win_count) r.status = kbib_pkg::ST_RANGE;
                else r.position = pos_mem[it.entry_index];
            end
        endcase
        r.window_count = idx_ok ? 17'(win_count) : 17'd0;
        return r;
    endfunction

    task automatic send_item(kbib_pkg::t_in it);
        if ($urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= '0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        result_fifo.push_back(predict_result(it));
    endtask

    task automatic send_cmd(kbib_pkg::t_cmd c, logic [1:0] b, logic [15:0] k,
                            logic [15:0] e);
        kbib_pkg::t_in it;
        it.command     = c;
        it.base        = b;
        it.query_kmer  = k;
        it.entry_index = e;
        send_item(it);
    endtask

    task automatic drain();
        start  <= 1'b0;
        i_item <= '0;
        while (result_fifo.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        kbib_pkg::t_out exp_r;
        if (o_strobe) begin
            if (result_fifo.size() == 0) begin
                $display("%0t unexpected result: expected none actual %p", $time, o_result);
                error_count++;
            end else begin
                exp_r = result_fifo.pop_front();
                if (o_result.status !== exp_r.status)
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $time, exp_r.status, o_result.status);
                if (o_result.window_count !== exp_r.window_count)
                    $display("%0t window_count mismatch: expected %0d actual %0d",
                             $time, exp_r.window_count, o_result.window_count);
                if (o_result.bucket_begin !== exp_r.bucket_begin)
                    $display("%0t bucket_begin mismatch: expected %0d actual %0d",
                             $time, exp_r.bucket_begin, o_result.bucket_begin);
                if (o_result.bucket_end !== exp_r.bucket_end)
                    $display("%0t bucket_end mismatch: expected %0d actual %0d",
                             $time, exp_r.bucket_end, o_result.bucket_end);
                if (o_result.position !== exp_r.position)
                    $display("%0t position mismatch: expected %0d actual %0d",
                             $time, exp_r.position, o_result.position);
                if (o_result !== exp_r) error_count++;
            end
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic test_before_build();
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_READ, 2'd0, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_BUILD, 2'd0, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_READ, 2'd0, 16'd0, 16'd0);
    endtask

    task automatic test_short_sequence();
        send_cmd(kbib_pkg::CMD_APPEND, 2'd3, 16'hFFFF, 16'hFFFF);
        send_cmd(kbib_pkg::CMD_APPEND, 2'd1, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_BUILD, 2'd0, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, 16'hFFFF, 16'd0);
        send_cmd(kbib_pkg::CMD_READ, 2'd0, 16'd0, 16'd0);
    endtask

    task automatic test_directed_index();
        for (int i = 0; i < 8; i++) send_cmd(kbib_pkg::CMD_APPEND, 2'(i), 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_BUILD, 2'd0, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, hash_at(0), 16'd0);
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, hash_at(2), 16'd0);
        send_cmd(kbib_pkg::CMD_READ, 2'd0, 16'd0, 16'd2);
        send_cmd(kbib_pkg::CMD_READ, 2'd0, 16'd0, 16'hFFFF);
        send_cmd(kbib_pkg::CMD_APPEND, 2'd2, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, 16'd0, 16'd0);
    endtask

    task automatic random_phase(int n_items, int pct);
        int sel;
        idle_pct = pct;
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                send_cmd(kbib_pkg::CMD_APPEND, 2'($urandom_range(3)), 16'($urandom),
                         16'($urandom));
            end else if (sel < 47 && builds_done < 14) begin
                send_cmd(kbib_pkg::CMD_BUILD, 2'($urandom_range(3)), 16'($urandom),
                         16'($urandom));
                builds_done++;
            end else if (sel < 75) begin
                if (idx_ok && win_count > 0 && $urandom_range(3) != 0)
                    send_cmd(kbib_pkg::CMD_QUERY, 2'($urandom_range(3)),
                             hash_at($urandom_range(win_count - 1)), 16'($urandom));
                else
                    send_cmd(kbib_pkg::CMD_QUERY, 2'($urandom_range(3)), 16'($urandom),
                             16'($urandom));
            end else begin
                if (idx_ok && win_count > 0 && $urandom_range(3) != 0)
                    send_cmd(kbib_pkg::CMD_READ, 2'($urandom_range(3)), 16'($urandom),
                             16'($urandom_range(win_count - 1)));
                else
                    send_cmd(kbib_pkg::CMD_READ, 2'($urandom_range(3)), 16'($urandom),
                             16'($urandom));
            end
        end
        send_cmd(kbib_pkg::CMD_BUILD, 2'd0, 16'd0, 16'd0);
        for (int i = 0; i < 40; i++)
            send_cmd($urandom_range(1) ? kbib_pkg::CMD_QUERY : kbib_pkg::CMD_READ, 2'd0,
                     16'($urandom_range(win_count + 3)), 16'($urandom_range(win_count + 3)));
    endtask

    task automatic test_final_index();
        idle_pct = 0;
        send_cmd(kbib_pkg::CMD_BUILD, 2'd0, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, hash_at(seq_len - kbib_pkg::KMER_LENGTH), 16'd0);
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, 16'hFFFF, 16'd0);
        send_cmd(kbib_pkg::CMD_READ, 2'd0, 16'd0, 16'(win_count - 1));
        send_cmd(kbib_pkg::CMD_READ, 2'd0, 16'd0, 16'(win_count));
        send_cmd(kbib_pkg::CMD_READ, 2'd0, 16'd0, 16'hFFFF);
        send_cmd(kbib_pkg::CMD_APPEND, 2'd3, 16'd0, 16'd0);
        send_cmd(kbib_pkg::CMD_QUERY, 2'd0, 16'd0, 16'd0);
    endtask

    initial begin
        int drain_cnt;
        start       = 1'b0;
        i_item      = '0;
        i_rst_n     = 1'b0;
        seq_len     = 0;
        win_count   = 0;
        idx_ok      = 1'b0;
        error_count = 0;
        idle_pct    = 33;
        builds_done = 0;
        for (int j = 0; j < kbib_pkg::DIR_DEPTH; j++) bucket_dir[j] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_build();
        test_short_sequence();
        test_directed_index();
        drain();
        random_phase(380, 33);
        drain();
        random_phase(380, 0);
        test_final_index();

        start  <= 1'b0;
        i_item <= '0;
        drain_cnt = 0;
        while (result_fifo.size() != 0 && drain_cnt < 1000) begin
            @(posedge i_clk);
            drain_cnt++;
        end
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && result_fifo.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/kbib_pkg.sv
hw/rtl/kbib_ram.sv
hw/rtl/kmer_bucket_index_builder.sv
hw/rtl/kbib_checker.sv
tb/sv/kmer_bucket_index_builder_tb.sv
